>>> src/shd_pkg.sv
// Package for the star/hash packet deframer.
// Holds the delimiter codes and default sizes; no dependencies.
`default_nettype none
package shd_pkg;
   localparam int BYTE_W       = 8;
   localparam int BUFFER_BYTES = 32;
   localparam int MIN_HELD     = 3;
   localparam logic [BYTE_W-1:0] CH_START = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
endpackage
`default_nettype wire

>>> src/shd_req_if.sv
// Input channel of the deframer: one received byte per beat.
// Depends on shd_pkg for the byte width.
`default_nettype none
interface shd_req_if;
   logic                      valid;
   logic                      ready;
   logic [shd_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> src/shd_rsp_if.sv
// Result channel of the deframer: one packet byte per beat plus end flag.
// Depends on shd_pkg for the byte width.
`default_nettype none
interface shd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [shd_pkg::BYTE_W-1:0] packet_byte;
   logic                      last_of_packet;
   modport source (output valid, output packet_byte, output last_of_packet, input ready);
   modport sink (input valid, input packet_byte, input last_of_packet, output ready);
endinterface
`default_nettype wire

>>> src/star_hash_packet_deframer.sv
// Star/hash packet deframer top level: window bookkeeping, packet read-out
// sequencer and result register. Depends on shd_pkg, shd_req_if, shd_rsp_if
// and shd_window_ram.
//
//   channel | dir | beat contents
//   req     | in  | rx_byte
//   rsp     | out | packet_byte, last_of_packet
//
// req is ready whenever no read-out runs. A closing '#' starts a read-out of
// L bytes (L <= BUFFER_BYTES) from the single window read port, one byte a
// cycle while rsp.ready does not hold back a waiting beat; req is held off
// during the read-out. Each beat passes the RAM read register and then the
// output register on its way to rsp.
// Synchronous active-high reset empties the window; the store itself is not
// cleared, as only written slots are ever read.
`default_nettype none
module star_hash_packet_deframer #(
   parameter int BUFFER_BYTES = shd_pkg::BUFFER_BYTES
) (
   input wire logic   clock,
   input wire logic   reset,
   shd_req_if.sink    req,
   shd_rsp_if.source  rsp
);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam logic [CW-1:0] FULL     = CW'(BUFFER_BYTES);
   localparam logic [CW:0]   N_WIDE   = (CW + 1)'(BUFFER_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_BYTES - 1);
   localparam logic [CW-1:0] MIN_FILL = CW'(shd_pkg::MIN_HELD);

   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic          star_seen_ff, star_seen_in;
   logic [AW-1:0] star_slot_ff, star_slot_in;
   logic          emit_ff, emit_in;
   logic [AW-1:0] rd_slot_ff, rd_slot_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          rd_last_ff, rd_last_in;
   logic          out_valid_ff, out_valid_in;
   logic [shd_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;

   logic          accept, full, trigger, issue, move;
   logic [CW:0]   sum, span;
   logic [AW-1:0] slot;
   logic          seen_new;
   logic [CW-1:0] fill_new;
   logic [shd_pkg::BYTE_W-1:0] rd_data;

   assign accept = req.valid && req.ready;
   assign full   = (fill_ff == FULL);
   assign sum    = (CW + 1)'(oldest_ff) + (CW + 1)'(fill_ff);

   always_comb begin
      if (full) begin
         slot = oldest_ff;
      end else if (sum >= N_WIDE) begin
         slot = AW'(sum - N_WIDE);
      end else begin
         slot = AW'(sum);
      end
      seen_new = star_seen_ff && !(full && (star_slot_ff == slot));
      fill_new = full ? fill_ff : fill_ff + CW'(1);
      if (slot >= star_slot_ff) begin
         span = (CW + 1)'(slot) - (CW + 1)'(star_slot_ff);
      end else begin
         span = (CW + 1)'(slot) + N_WIDE - (CW + 1)'(star_slot_ff);
      end
   end

   assign trigger = accept && (fill_new >= MIN_FILL) && (req.rx_byte == shd_pkg::CH_END)
                    && seen_new;

   assign move  = rd_valid_ff && (!out_valid_ff || rsp.ready);
   assign issue = emit_ff && (!rd_valid_ff || move);

   always_comb begin
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      star_seen_in = star_seen_ff;
      star_slot_in = star_slot_ff;
      emit_in      = emit_ff;
      rd_slot_in   = rd_slot_ff;
      remain_in    = remain_ff;
      if (accept) begin
         fill_in      = fill_new;
         star_seen_in = seen_new;
         if (full) begin
            oldest_in = (oldest_ff == LAST_IDX) ? '0 : oldest_ff + AW'(1);
         end
         if (req.rx_byte == shd_pkg::CH_START) begin
            star_seen_in = 1'b1;
            star_slot_in = slot;
         end
      end
      if (trigger) begin
         emit_in      = 1'b1;
         rd_slot_in   = star_slot_ff;
         remain_in    = CW'(span + (CW + 1)'(1));
         fill_in      = '0;
         oldest_in    = '0;
         star_seen_in = 1'b0;
         star_slot_in = '0;
      end
      if (issue) begin
         rd_slot_in = (rd_slot_ff == LAST_IDX) ? '0 : rd_slot_ff + AW'(1);
         remain_in  = remain_ff - CW'(1);
         emit_in    = (remain_ff != CW'(1));
      end
   end

   always_comb begin
      rd_valid_in  = issue || (rd_valid_ff && !move);
      rd_last_in   = issue ? (remain_ff == CW'(1)) : rd_last_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data;
         out_last_in  = rd_last_ff;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         oldest_ff    <= '0;
         star_seen_ff <= 1'b0;
         star_slot_ff <= '0;
         emit_ff      <= 1'b0;
         remain_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         star_seen_ff <= star_seen_in;
         star_slot_ff <= star_slot_in;
         emit_ff      <= emit_in;
         remain_ff    <= remain_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      rd_slot_ff  <= rd_slot_in;
      rd_last_ff  <= rd_last_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   shd_window_ram #(
      .DEPTH (BUFFER_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot),
      .wr_data (req.rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_slot_ff),
      .rd_data (rd_data)
   );

   assign req.ready          = !emit_ff;
   assign rsp.valid          = out_valid_ff;
   assign rsp.packet_byte    = out_byte_ff;
   assign rsp.last_of_packet = out_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL) else $error("window fill beyond depth");
   a_emit_remain: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> remain_ff != '0) else $error("read-out active with nothing left");
   a_read_held: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && !move) |=> rd_valid_ff) else $error("read data dropped");
   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> full) else $error("oldest slot moved before window full");
   a_star_held: assert property (@(posedge clock) disable iff (reset)
      star_seen_ff |-> fill_ff != '0) else $error("start mark flagged in empty window");
endmodule
`default_nettype wire

>>> src/shd_window_ram.sv
// Byte window store: one write port, one read port with registered data.
// Depends on shd_pkg for the byte width.
`default_nettype none
module shd_window_ram #(
   parameter int DEPTH = shd_pkg::BUFFER_BYTES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [shd_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [shd_pkg::BYTE_W-1:0] rd_data
);
   logic [shd_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [shd_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> sim/shd_packet_checker.sv
// Scoreboard for the star/hash packet deframer: mirrors the byte window,
// predicts packet beats and compares them with the rsp channel.
// Depends on shd_pkg, shd_req_if and shd_rsp_if.
`default_nettype none
module shd_packet_checker #(
   parameter int DEPTH = shd_pkg::BUFFER_BYTES
) (
   input wire logic clock,
   input wire logic reset,
   shd_req_if       req,
   shd_rsp_if       rsp,
   output int       mismatches,
   output int       awaited
);
   typedef struct packed {
      logic [shd_pkg::BYTE_W-1:0] data;
      logic                       last;
   } beat_type;

   beat_type                   packet_beats_due[$];
   beat_type                   want;
   logic [shd_pkg::BYTE_W-1:0] window_bytes [DEPTH];
   int                         held_count;
   int                         head_slot;
   bit                         star_held;
   int                         star_pos;

   // window bookkeeping for one received byte; queues the packet it closes
   task automatic absorb_byte(input logic [shd_pkg::BYTE_W-1:0] b);
      int slot;
      int len;
      int k;
      beat_type beat;
      if (held_count >= DEPTH) begin
         slot = head_slot;
         if (star_held && star_pos == slot)
            star_held = 1'b0;
         head_slot = (head_slot + 1) % DEPTH;
      end else begin
         slot = (head_slot + held_count) % DEPTH;
         held_count++;
      end
      window_bytes[slot] = b;
      if (b == shd_pkg::CH_START) begin
         star_held = 1'b1;
         star_pos  = slot;
      end
      if (held_count >= shd_pkg::MIN_HELD && b == shd_pkg::CH_END && star_held) begin
         len = (slot + DEPTH - star_pos) % DEPTH + 1;
         for (k = 0; k < len; k++) begin
            beat.data = window_bytes[(star_pos + k) % DEPTH];
            beat.last = (k == len - 1);
            packet_beats_due.push_back(beat);
         end
         held_count = 0;
         head_slot  = 0;
         star_held  = 1'b0;
         star_pos   = 0;
      end
   endtask

   function automatic void note_mismatch(input string what);
      if (mismatches < 10)
         $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endfunction

   initial begin
      mismatches = 0;
      awaited    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         head_slot  = 0;
         star_held  = 1'b0;
         star_pos   = 0;
         packet_beats_due.delete();
      end else begin
         if (req.valid === 1'b1 && req.ready === 1'b1)
            absorb_byte(req.rx_byte);
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (packet_beats_due.size() == 0) begin
               note_mismatch($sformatf("unexpected beat byte=%h last=%b",
                                       rsp.packet_byte, rsp.last_of_packet));
            end else begin
               want = packet_beats_due.pop_front();
               if (rsp.packet_byte !== want.data || rsp.last_of_packet !== want.last)
                  note_mismatch($sformatf("byte exp %h got %h, last exp %b got %b",
                                          want.data, rsp.packet_byte,
                                          want.last, rsp.last_of_packet));
            end
         end
      end
      awaited = packet_beats_due.size();
   end
endmodule
`default_nettype wire

>>> sim/star_hash_packet_deframer_tb.sv
// Testbench top for the star/hash packet deframer: clock, reset, byte
// stimulus and rsp back-pressure; checking is done by shd_packet_checker.
// Depends on shd_pkg, shd_req_if, shd_rsp_if and the deframer RTL.
`default_nettype none
module star_hash_packet_deframer_tb;
   localparam int DEPTH        = shd_pkg::BUFFER_BYTES;
   localparam int BW           = shd_pkg::BYTE_W;
   localparam int ITEMS        = 210;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_OFF     = 200;
   localparam int DRAIN_CYCLES = DEPTH + 16;

   logic clock;
   logic reset;
   int   cycle_count;
   int   accepted;
   int   mismatches;
   int   awaited;
   bit   squeeze_done;

   shd_req_if req ();
   shd_rsp_if rsp ();

   star_hash_packet_deframer u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   shd_packet_checker #(.DEPTH(DEPTH)) u_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   int calm_items;

   task automatic send_byte(input logic [BW-1:0] b);
      int gap;
      if (calm_items > 0) begin
         calm_items--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0)
            calm_items = $urandom_range(10, 30);
         gap = pick_gap();
      end
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      do @(posedge clock); while (req.ready !== 1'b1);
      accepted++;
   endtask

   // marks_ok clear: no '*' or '#' among the bytes
   task automatic send_payload(input int n, input bit marks_ok);
      int i;
      logic [BW-1:0] b;
      for (i = 0; i < n; i++) begin
         do b = BW'($urandom_range(0, 255));
         while (!marks_ok && (b == shd_pkg::CH_START || b == shd_pkg::CH_END));
         send_byte(b);
      end
   endtask

   // rsp back-pressure, with one long hold-off while the sender keeps going
   initial begin
      int stall_left;
      int calm_left;
      stall_left   = 0;
      calm_left    = 0;
      squeeze_done = 1'b0;
      rsp.ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (!squeeze_done && !reset && accepted >= 60 && rsp.valid === 1'b1) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            squeeze_done = 1'b1;
         end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp.ready <= 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 49) == 0)
               calm_left = $urandom_range(40, 120);
            else if ($urandom_range(0, 2) == 0)
               stall_left = pick_gap();
         end
      end
   end

   initial begin
      int pick;
      int n;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.rx_byte = '0;
      accepted    = 0;
      calm_items  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no start mark, then a minimal packet
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(shd_pkg::CH_END);
      send_byte(shd_pkg::CH_START);
      send_byte(shd_pkg::CH_END);
      // short window, then the third byte closes the packet
      send_byte(shd_pkg::CH_START);
      send_byte(shd_pkg::CH_END);
      send_byte(shd_pkg::CH_END);
      // lone hash, then a packet after noise
      send_byte(shd_pkg::CH_END);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(shd_pkg::CH_START);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(shd_pkg::CH_END);
      // two stars: the later one opens the packet
      send_byte(shd_pkg::CH_START);
      send_byte(8'h01);
      send_byte(shd_pkg::CH_START);
      send_byte(8'h02);
      send_byte(shd_pkg::CH_END);
      // extreme payload bytes
      send_byte(shd_pkg::CH_START);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(shd_pkg::CH_END);

      while (accepted < ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_payload($urandom_range(0, 3), 1'b1);
            send_byte(shd_pkg::CH_START);
            if ($urandom_range(0, 9) == 0)
               n = $urandom_range(DEPTH / 2, DEPTH - 1);
            else
               n = $urandom_range(0, 6);
            send_payload(n, $urandom_range(0, 7) == 0);
            send_byte(shd_pkg::CH_END);
         end else if (pick < 80) begin
            send_payload($urandom_range(1, 8), 1'b1);
         end else if (pick < 90) begin
            send_byte(shd_pkg::CH_START);
            send_payload($urandom_range(0, 4), 1'b0);
         end else begin
            send_payload($urandom_range(DEPTH + 1, DEPTH + 12), 1'b0);
         end
      end

      @(negedge clock);
      req.valid <= 1'b0;
      wait (awaited == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
